// ===== rtl/core/poa_pkg.sv =====
// Shared types and constants for the prescaled oversampling averager.
// Used by the top level, the divider, the port checker and the testbench.
// No dependencies.
package poa_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int OVS_W        = 4;
	localparam int PRESCALE_W   = 12;
	localparam int CFG_ADDR_W   = 1;
	localparam int CFG_DATA_W   = 12;
	localparam int STORE_DEPTH  = 16;
	localparam int STORE_ADDR_W = 4;
	// sum of up to sixteen 32-bit samples
	localparam int SUM_W        = 36;
	// divisor is oversample_extra + 1, at most sixteen
	localparam int DIVISOR_W    = 5;
	// two quotient bits per cycle
	localparam int DIV_STEPS    = SUM_W / 2;
	localparam int DIV_CNT_W    = 5;

	localparam logic [OVS_W-1:0]      MAX_OVERSAMPLE = 4'd15;
	localparam logic [PRESCALE_W-1:0] MAX_PRESCALE   = 12'd4095;

	localparam logic [CFG_ADDR_W-1:0] REG_OVERSAMPLE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE   = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_PRESCALE = 2'd1,
		ACT_SAMPLE   = 2'd2,
		ACT_OUTPUT   = 2'd3
	} action_t;

endpackage

// ===== rtl/core/poa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module poa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/poa_div.sv =====
// Iterative signed-by-unsigned divider, two quotient bits per cycle, truncating toward zero.
// Depends on poa_pkg.
module poa_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [poa_pkg::SUM_W-1:0]     dividend,
	input  logic [poa_pkg::DIVISOR_W-1:0]        divisor,
	output logic                                 done,
	output logic signed [poa_pkg::SAMPLE_W-1:0]  quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;
	logic [poa_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [poa_pkg::SUM_W-1:0]         mag_q;
	logic [poa_pkg::DIVISOR_W-2:0]     rem_q;
	logic [poa_pkg::DIVISOR_W-1:0]     d_q;

	logic [poa_pkg::DIVISOR_W-1:0]     r1, r2;
	logic                              ge1, ge2;
	logic [poa_pkg::DIVISOR_W-2:0]     rem1, rem2;
	logic [poa_pkg::SUM_W-1:0]         signed_q;

	always_comb begin
		r1   = {rem_q, mag_q[poa_pkg::SUM_W-1]};
		ge1  = (r1 >= d_q);
		rem1 = ge1 ? 4'(r1 - d_q) : r1[poa_pkg::DIVISOR_W-2:0];
		r2   = {rem1, mag_q[poa_pkg::SUM_W-2]};
		ge2  = (r2 >= d_q);
		rem2 = ge2 ? 4'(r2 - d_q) : r2[poa_pkg::DIVISOR_W-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			mag_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= dividend[poa_pkg::SUM_W-1];
				mag_q  <= dividend[poa_pkg::SUM_W-1] ? 36'(-dividend) : 36'(dividend);
				rem_q  <= '0;
				d_q    <= divisor;
				cnt_q  <= 5'(poa_pkg::DIV_STEPS);
			end else if (busy_q) begin
				mag_q <= {mag_q[poa_pkg::SUM_W-3:0], ge1, ge2};
				rem_q <= rem2;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign signed_q = neg_q ? (~mag_q + 36'd1) : mag_q;
	assign quotient = signed_q[poa_pkg::SAMPLE_W-1:0];
	assign done     = done_q;

endmodule

// ===== rtl/core/prescaled_oversampling_averager_top.sv =====
// Top level of the prescaled oversampling averager.
// Depends on poa_pkg, poa_ram and poa_div.
//
// Usage: every request on the s_axis channel is one tick with a signed 32-bit
// sample. Each tick yields exactly one result on m_axis: tuser carries the
// tick action (none, prescale, sample, sample and output) and tdata the
// truncated mean of the first oversample_extra+1 stored samples, zero unless
// the action is sample and output.
// Configuration: cfg_we with cfg_addr 0 writes oversample_extra, 1 writes
// prescale_ticks; either write clears both down-counters. Write only while idle.
// Path from accept to result valid:
//   none / prescale / sample tick: straight to the output register
//   output tick: one store read per cycle for the sum over the entries, then
//   the radix-4 divider, then the output register
//   the first sampling tick after reset first fills every store entry
// One tick is in flight at a time; s_axis_tready is high only when idle.
// A finished result sits in the output register, so the next tick is taken
// while the receiver stalls; a second result waits until the first is taken.
// Reset clears registers, counters and the primed flag; store contents stay
// undefined until the first sample fills every entry.
module prescaled_oversampling_averager_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [31:0]                         s_axis_tdata,  // [31:0] sample
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [31:0]                         m_axis_tdata,  // [31:0] average
	output logic [1:0]                          m_axis_tuser,  // [1:0] tick_action
	input  logic                                cfg_we,
	input  logic [poa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [poa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SUM,
		ST_SUMLAST,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_EMIT
	} state_t;

	state_t                                state_q;
	logic [poa_pkg::OVS_W-1:0]             ovs_extra_q;
	logic [poa_pkg::PRESCALE_W-1:0]        prescale_ticks_q;
	logic [poa_pkg::PRESCALE_W-1:0]        prescale_cnt_q;
	logic [poa_pkg::OVS_W-1:0]             ovs_cnt_q;
	logic                                  primed_q;
	poa_pkg::action_t                      act_q;
	logic [poa_pkg::SAMPLE_W-1:0]          sample_q;
	logic [poa_pkg::STORE_ADDR_W-1:0]      idx_q;
	logic                                  rd_pend_s1;
	logic signed [poa_pkg::SUM_W-1:0]      acc_q;
	logic signed [poa_pkg::SAMPLE_W-1:0]   avg_q;
	logic                                  out_valid_q;
	poa_pkg::action_t                      out_act_q;
	logic [poa_pkg::SAMPLE_W-1:0]          out_avg_q;

	poa_pkg::action_t                      act_in;
	logic                                  accept;
	logic                                  sampling;
	logic                                  ram_we;
	logic [poa_pkg::STORE_ADDR_W-1:0]      ram_waddr;
	logic [poa_pkg::SAMPLE_W-1:0]          ram_wdata;
	logic [poa_pkg::SAMPLE_W-1:0]          ram_rdata;
	logic                                  div_done;
	logic signed [poa_pkg::SAMPLE_W-1:0]   div_quot;
	logic [poa_pkg::DIVISOR_W-1:0]         divisor;
	logic [poa_pkg::OVS_W-1:0]             ovs_wr;
	logic [poa_pkg::PRESCALE_W-1:0]        prescale_wr;
	logic                                  out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign divisor       = {1'b0, ovs_extra_q} + 5'd1;

	always_comb begin
		if (prescale_ticks_q == '0) begin
			act_in = poa_pkg::ACT_NONE;
		end else if (prescale_cnt_q != '0) begin
			act_in = poa_pkg::ACT_PRESCALE;
		end else if (ovs_cnt_q != '0) begin
			act_in = poa_pkg::ACT_SAMPLE;
		end else begin
			act_in = poa_pkg::ACT_OUTPUT;
		end
		sampling = (act_in == poa_pkg::ACT_SAMPLE) || (act_in == poa_pkg::ACT_OUTPUT);
	end

	// register write values: oversample_extra takes the low four data bits, so neither clamp to the maximum applies
	assign ovs_wr      = (cfg_wdata[poa_pkg::OVS_W-1:0] > poa_pkg::MAX_OVERSAMPLE)
	                     ? poa_pkg::MAX_OVERSAMPLE : cfg_wdata[poa_pkg::OVS_W-1:0];
	assign prescale_wr = (cfg_wdata > poa_pkg::MAX_PRESCALE) ? poa_pkg::MAX_PRESCALE : cfg_wdata;

	// primed store takes the sample at the counter slot on accept; otherwise the fill sweep
	always_comb begin
		if (state_q == ST_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
			ram_wdata = sample_q;
		end else begin
			ram_we    = accept && sampling && primed_q;
			ram_waddr = ovs_cnt_q;
			ram_wdata = s_axis_tdata;
		end
	end

	poa_ram #(
		.WIDTH (poa_pkg::SAMPLE_W),
		.DEPTH (poa_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	poa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIVGO),
		.dividend (acc_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			ovs_extra_q      <= '0;
			prescale_ticks_q <= '0;
			prescale_cnt_q   <= '0;
			ovs_cnt_q        <= '0;
			primed_q         <= 1'b0;
			act_q            <= poa_pkg::ACT_NONE;
			sample_q         <= '0;
			idx_q            <= '0;
			rd_pend_s1       <= 1'b0;
			acc_q            <= '0;
			avg_q            <= '0;
			out_valid_q      <= 1'b0;
			out_act_q        <= poa_pkg::ACT_NONE;
			out_avg_q        <= '0;
		end else begin
			rd_pend_s1 <= (state_q == ST_SUM);
			if (rd_pend_s1) begin
				acc_q <= acc_q + {{(poa_pkg::SUM_W-poa_pkg::SAMPLE_W){ram_rdata[31]}}, ram_rdata};
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_addr)
					poa_pkg::REG_OVERSAMPLE: ovs_extra_q      <= ovs_wr;
					poa_pkg::REG_PRESCALE:   prescale_ticks_q <= prescale_wr;
					default: ;
				endcase
				prescale_cnt_q <= '0;
				ovs_cnt_q      <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q    <= act_in;
						sample_q <= s_axis_tdata;
						idx_q    <= '0;
						acc_q    <= '0;
						state_q  <= ST_EMIT;
						unique case (act_in)
							poa_pkg::ACT_NONE: begin
								prescale_cnt_q <= '0;
								ovs_cnt_q      <= '0;
							end
							poa_pkg::ACT_PRESCALE: begin
								prescale_cnt_q <= prescale_cnt_q - 12'd1;
							end
							default: begin
								prescale_cnt_q <= prescale_ticks_q - 12'd1;
								ovs_cnt_q      <= (ovs_cnt_q != '0) ? ovs_cnt_q - 4'd1 : ovs_extra_q;
								if (!primed_q) begin
									state_q <= ST_FILL;
								end else if (act_in == poa_pkg::ACT_OUTPUT) begin
									state_q <= ST_SUM;
								end
							end
						endcase
					end
				end
				ST_FILL: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'(poa_pkg::STORE_DEPTH - 1)) begin
						primed_q <= 1'b1;
						state_q  <= (act_q == poa_pkg::ACT_OUTPUT) ? ST_SUM : ST_EMIT;
					end
				end
				ST_SUM: begin
					// issue one store read per cycle over entries 0..oversample_extra
					idx_q <= idx_q + 4'd1;
					if (idx_q == ovs_extra_q) begin
						state_q <= ST_SUMLAST;
					end
				end
				ST_SUMLAST: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						avg_q   <= div_quot;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_act_q   <= act_q;
						out_avg_q   <= (act_q == poa_pkg::ACT_OUTPUT) ? avg_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_avg_q;
	assign m_axis_tuser  = out_act_q;

endmodule

// ===== rtl/core/poa_checker.sv =====
// Port-level checker for the prescaled oversampling averager, bound to the top level.
// Depends on poa_pkg.
module poa_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [31:0]                     m_axis_tdata,
	input  logic [1:0]                      m_axis_tuser
);

	// average is only reported on output ticks
	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != poa_pkg::ACT_OUTPUT)) |-> (m_axis_tdata == '0))
		else $error("nonzero average on a tick without output");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");

	// one tick in flight: the block is not ready right after an accepted request
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted on consecutive cycles");

	// a result never appears in the cycle right after a request was taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result produced too early");

endmodule

bind prescaled_oversampling_averager_top poa_checker u_poa_checker (.*);

// ===== sim/tb.sv =====
// Testbench for prescaled_oversampling_averager_top: random and directed ticks with stalls.
// A scoreboard class predicts each tick's action and average and checks every result.
// Depends on poa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

	localparam int TICK_TARGET = 1500;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		poa_pkg::action_t act;
		logic [31:0]      avg;
	} tick_result_t;

	class averager_scoreboard;
		logic [poa_pkg::OVS_W-1:0]      ovs_extra;
		logic [poa_pkg::PRESCALE_W-1:0] prescale_ticks;
		logic [poa_pkg::PRESCALE_W-1:0] prescale_left;
		logic [poa_pkg::OVS_W-1:0]      ovs_left;
		logic signed [31:0]             sample_slots [poa_pkg::STORE_DEPTH];
		bit                             primed;
		tick_result_t                   awaited_results [$];
		int                             errors;
		int                             reg_writes;
		int                             action_seen [4];

		function new();
			ovs_extra      = '0;
			prescale_ticks = '0;
			prescale_left  = '0;
			ovs_left       = '0;
			primed         = 1'b0;
			errors         = 0;
			reg_writes     = 0;
			foreach (sample_slots[i]) sample_slots[i] = '0;
			foreach (action_seen[i]) action_seen[i] = 0;
		endfunction

		function void write_reg(logic [poa_pkg::CFG_ADDR_W-1:0] addr,
			logic [poa_pkg::CFG_DATA_W-1:0] data);
			case (addr)
				poa_pkg::REG_OVERSAMPLE: begin
					ovs_extra = (data[poa_pkg::OVS_W-1:0] > poa_pkg::MAX_OVERSAMPLE)
						? poa_pkg::MAX_OVERSAMPLE : data[poa_pkg::OVS_W-1:0];
				end
				poa_pkg::REG_PRESCALE: begin
					prescale_ticks = (data > poa_pkg::MAX_PRESCALE) ? poa_pkg::MAX_PRESCALE
						: data;
				end
				default: return;
			endcase
			prescale_left = '0;
			ovs_left      = '0;
			reg_writes++;
		endfunction

		// Advance the down-counters by one tick and work out its result.
		function tick_result_t advance_channel(logic [31:0] s);
			tick_result_t r;
			longint       total;
			int           n;
			r.act = poa_pkg::ACT_NONE;
			r.avg = '0;
			if (prescale_ticks == 0) begin
				prescale_left = '0;
				ovs_left      = '0;
			end else if (prescale_left != 0) begin
				r.act = poa_pkg::ACT_PRESCALE;
				prescale_left--;
			end else begin
				r.act = (ovs_left != 0) ? poa_pkg::ACT_SAMPLE : poa_pkg::ACT_OUTPUT;
				if (primed) begin
					sample_slots[ovs_left] = s;
				end else begin
					foreach (sample_slots[i]) sample_slots[i] = s;
					primed = 1'b1;
				end
				if (r.act == poa_pkg::ACT_OUTPUT) begin
					total = 0;
					n = int'(ovs_extra) + 1;
					for (int i = 0; i < n; i++) total += longint'(sample_slots[i]);
					r.avg = 32'(total / n);
				end
				prescale_left = prescale_ticks - 12'd1;
				if (ovs_left != 0) ovs_left--;
				else ovs_left = ovs_extra;
			end
			return r;
		endfunction

		function void note_tick(logic [31:0] s);
			awaited_results.push_back(advance_channel(s));
		endfunction

		function void check_result(logic [1:0] user, logic [31:0] data);
			tick_result_t exp_r;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited: action %0d average %h",
					$time, user, data);
				errors++;
				return;
			end
			exp_r = awaited_results.pop_front();
			action_seen[exp_r.act]++;
			if (user !== exp_r.act) begin
				$display("%0t: tick_action expected %0d actual %0d", $time, exp_r.act, user);
				errors++;
			end
			if (data !== exp_r.avg) begin
				$display("%0t: average expected %h actual %h", $time, exp_r.avg, data);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [31:0]                    s_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [31:0]                    m_axis_tdata;
	logic [1:0]                     m_axis_tuser;
	logic                           cfg_we;
	logic [poa_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [poa_pkg::CFG_DATA_W-1:0] cfg_wdata;

	averager_scoreboard sb;
	int src_idle_pct;
	int sink_stall_pct;
	int ticks_sent;
	int settings_run;

	prescaled_oversampling_averager_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: check accepted results, stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Hold valid until the request is taken; lower it only while idling.
	task automatic send_tick(logic [31:0] s);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= s;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_tick(s);
		ticks_sent++;
	endtask

	task automatic write_register(logic [poa_pkg::CFG_ADDR_W-1:0] addr,
		logic [poa_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(addr, data);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
			default: begin src_idle_pct = 34; sink_stall_pct = 34; end
		endcase
	endtask

	initial begin
		int                             n_ticks;
		int                             pick;
		logic [31:0]                    s;
		logic [poa_pkg::CFG_DATA_W-1:0] ovs_data;
		logic [poa_pkg::CFG_DATA_W-1:0] pre_data;

		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		ticks_sent = 0;
		settings_run = 1;
		set_idling(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings leave the channel inactive.
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		drain();

		// Average of one: first sample primes the store, then the extremes.
		write_register(poa_pkg::REG_OVERSAMPLE, 12'h000);
		write_register(poa_pkg::REG_PRESCALE, 12'h001);
		cfg_we <= 1'b0;
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		send_tick(32'hFFFF_FFFF);
		drain();

		// Full store of the largest value, sum at its widest.
		write_register(poa_pkg::REG_OVERSAMPLE, 12'hFFF);
		write_register(poa_pkg::REG_PRESCALE, 12'h001);
		cfg_we <= 1'b0;
		repeat (17) send_tick(32'h7FFF_FFFF);
		drain();

		// Longest prescale, then inactive again to force the counters to zero.
		write_register(poa_pkg::REG_PRESCALE, 12'hFFF);
		cfg_we <= 1'b0;
		send_tick(32'h8000_0000);
		send_tick(32'h0000_0000);
		drain();
		write_register(poa_pkg::REG_PRESCALE, 12'h000);
		cfg_we <= 1'b0;
		send_tick($urandom());
		drain();
		settings_run += 4;

		while (ticks_sent < TICK_TARGET) begin
			set_idling(settings_run % 4);
			ovs_data = 12'($urandom_range(0, 4095));
			pick = $urandom_range(0, 19);
			if (pick == 0) pre_data = 12'h000;
			else if (pick == 1) pre_data = 12'hFFF;
			else if (pick == 2) pre_data = 12'($urandom_range(5, 4095));
			else pre_data = 12'($urandom_range(1, 4));
			case ($urandom_range(0, 3))
				0: write_register(poa_pkg::REG_OVERSAMPLE, ovs_data);
				1: write_register(poa_pkg::REG_PRESCALE, pre_data);
				2: begin
					write_register(poa_pkg::REG_PRESCALE, pre_data);
					write_register(poa_pkg::REG_OVERSAMPLE, ovs_data);
				end
				default: begin
					write_register(poa_pkg::REG_OVERSAMPLE, ovs_data);
					write_register(poa_pkg::REG_PRESCALE, pre_data);
				end
			endcase
			cfg_we <= 1'b0;
			if (sb.prescale_ticks > 8 || sb.prescale_ticks == 0) n_ticks = $urandom_range(4, 12);
			else n_ticks = $urandom_range(40, 120);
			repeat (n_ticks) begin
				case ($urandom_range(0, 15))
					0: s = 32'h7FFF_FFFF;
					1: s = 32'h8000_0000;
					2: s = 32'hFFFF_FFFF;
					3: s = 32'($signed($urandom_range(0, 6)) - 3);
					default: s = $urandom();
				endcase
				send_tick(s);
			end
			drain();
			settings_run++;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("ran %0d ticks over %0d settings with %0d register writes",
			ticks_sent, settings_run, sb.reg_writes);
		$display("actions seen: none %0d, prescale %0d, sample %0d, output %0d",
			sb.action_seen[poa_pkg::ACT_NONE], sb.action_seen[poa_pkg::ACT_PRESCALE],
			sb.action_seen[poa_pkg::ACT_SAMPLE], sb.action_seen[poa_pkg::ACT_OUTPUT]);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never came", sb.errors, sb.outstanding());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/poa_pkg.sv
rtl/core/poa_ram.sv
rtl/core/poa_div.sv
rtl/core/prescaled_oversampling_averager_top.sv
rtl/core/poa_checker.sv
sim/tb.sv
